// ===== design/ttce_pkg.sv =====
// types and constants shared by the terminal cursor engine
`timescale 1ns / 1ps
package ttce_pkg;

  localparam int ROW_FW = 7;
  localparam int COL_FW = 8;

  localparam logic [7:0]  CODE_NL    = 8'd10;
  localparam logic [7:0]  CODE_CR    = 8'd13;
  localparam logic [7:0]  CODE_SPACE = 8'h20;
  localparam logic [11:0] PAD_PIX    = 12'd20;
  localparam int          COLS_FLOOR = 20;
  localparam int          ROWS_FLOOR = 6;
  localparam int          RST_COLS   = 60;
  localparam int          RST_ROWS   = 20;
  localparam logic [11:0] RST_WIDTH  = 12'd500;
  localparam logic [11:0] RST_HEIGHT = 12'd340;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_RESIZE = 2'd2,
    MODE_READ   = 2'd3
  } ttce_mode_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_SCROLL = 2'd3
  } ttce_op_e;

  typedef struct packed {
    ttce_mode_e  mode;
    logic [7:0]  char_code;
    logic [11:0] pixel_width;
    logic [11:0] pixel_height;
    logic [5:0]  read_row;
    logic [6:0]  read_col;
  } ttce_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic [6:0] column_count;
    logic [6:0] row_count;
    logic [7:0] cell_char;
    logic       scrolled;
  } ttce_result_t;

  typedef struct packed {
    ttce_op_e            op;
    logic [ROW_FW-1:0]   row;
    logic [COL_FW-1:0]   col;
    logic [7:0]          data;
    logic                blank_en;
  } ttce_cmd_t;

endpackage

// ===== design/ttce_cell_store.sv =====
// cell memory with clear, scroll-copy, last-row blank and single-cell access engine
`timescale 1ns / 1ps
module ttce_cell_store import ttce_pkg::*; #(
  parameter int MAX_COLUMNS = 120,
  parameter int MAX_LINES   = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ttce_cmd_t  cmd_i,
  output logic       done_o,
  output logic [7:0] rdata_o
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int STRIDE = 1 << COL_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_COPY,
    PH_BLANK
  } phase_e;

  logic [7:0]        mem_q [DEPTH];
  phase_e            phase_q;
  logic [ADDR_W-1:0] cnt_q;
  logic [ADDR_W-1:0] wa_q;
  logic [ROW_W-1:0]  last_row_q;
  logic              blank_en_q;
  logic              wv_q;
  logic              done_q;
  logic [7:0]        rd_q;

  logic [ADDR_W-1:0] cmd_addr;
  logic [ADDR_W-1:0] copy_end;
  logic              copy_issue;
  logic              col_last;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  assign cmd_addr   = {ROW_W'(cmd_i.row), COL_W'(cmd_i.col)};
  assign copy_end   = {last_row_q, {COL_W{1'b0}}};
  assign copy_issue = (phase_q == PH_COPY) && (cnt_q != copy_end);
  assign col_last   = &cnt_q[COL_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cmd_addr;
    wdata = cmd_i.data;
    re    = 1'b0;
    raddr = cmd_addr;
    unique case (phase_q)
      PH_IDLE: begin
        we = (cmd_i.op == OP_WRITE);
        re = (cmd_i.op == OP_READ);
      end
      PH_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = CODE_SPACE;
      end
      PH_COPY: begin
        we    = wv_q;
        waddr = wa_q;
        wdata = rd_q;
        re    = copy_issue;
        raddr = cnt_q + ADDR_W'(STRIDE);
      end
      PH_BLANK: begin
        we    = 1'b1;
        waddr = {last_row_q, cnt_q[COL_W-1:0]};
        wdata = CODE_SPACE;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (copy_issue) begin
      wa_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CLEAR;
      cnt_q      <= '0;
      wv_q       <= 1'b0;
      done_q     <= 1'b0;
      last_row_q <= '0;
      blank_en_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          wv_q <= 1'b0;
          unique case (cmd_i.op)
            OP_WRITE, OP_READ: begin
              done_q <= 1'b1;
            end
            OP_SCROLL: begin
              phase_q    <= PH_COPY;
              cnt_q      <= '0;
              last_row_q <= ROW_W'(cmd_i.row);
              blank_en_q <= cmd_i.blank_en;
            end
            OP_NONE: begin
              done_q <= 1'b0;
            end
            default: begin
              done_q <= 1'b0;
            end
          endcase
        end
        PH_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end
        end
        PH_COPY: begin
          if (copy_issue) begin
            cnt_q <= cnt_q + 1'b1;
            wv_q  <= 1'b1;
          end else begin
            wv_q <= 1'b0;
            if (!wv_q) begin
              if (blank_en_q) begin
                phase_q <= PH_BLANK;
                cnt_q   <= '0;
              end else begin
                phase_q <= PH_IDLE;
                done_q  <= 1'b1;
              end
            end
          end
        end
        PH_BLANK: begin
          cnt_q <= cnt_q + 1'b1;
          if (col_last) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  assign done_o  = done_q;
  assign rdata_o = rd_q;

endmodule

// ===== design/text_terminal_cursor_engine_core.sv =====
// top level of the character-cell terminal: cursor sequencer and cell store
// a scroll copies the cell store up by one row, one cell per cycle
// one word in flight: busy stays high from accept until the result strobe
// after reset busy holds while the store is filled with spaces;
// results cannot be held off
`timescale 1ns / 1ps
module text_terminal_cursor_engine_core import ttce_pkg::*; #(
  parameter int MAX_COLUMNS = 120,
  parameter int MAX_LINES   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  ttce_item_t   item_i,
  output logic         result_valid_o,
  output ttce_result_t result_o
);

  localparam int COL_TOP = (MAX_COLUMNS > RST_COLS) ? MAX_COLUMNS : RST_COLS;
  localparam int ROW_TOP = (MAX_LINES > RST_ROWS) ? MAX_LINES : RST_ROWS;
  localparam int CW = $clog2(COL_TOP + 1);
  localparam int RW = $clog2(ROW_TOP + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CELL,
    ST_SCROLL,
    ST_SWAIT,
    ST_RESP
  } state_e;

  state_e       state_q;
  ttce_item_t   item_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] line_q;
  logic [CW-1:0] cols_q;
  logic [RW-1:0] rows_q;
  logic [11:0]  width_q;
  logic [11:0]  height_q;
  logic         scrolled_q;
  logic         pend_q;
  logic [7:0]   cell_q;
  ttce_cmd_t    cmd_q;
  ttce_result_t res_q;
  logic         res_valid_q;

  logic         store_done;
  logic [7:0]   store_rdata;

  logic [11:0]   w_eff;
  logic [11:0]   h_eff;
  logic [11:0]   w_diff;
  logic [11:0]   h_diff;
  logic [8:0]    n_cols;
  logic [7:0]    n_rows;
  logic [CW-1:0] cols_new;
  logic [RW-1:0] rows_new;
  logic [CW-1:0] ex_col;
  logic [RW-1:0] ex_line;
  logic [CW-1:0] wa_col;
  logic [RW-1:0] wa_line;
  logic          ex_wr;
  logic          ex_rd;
  logic          ex_scroll;
  logic [7:0]    ex_data;
  logic [RW-1:0] rows_lim;
  logic [RW-1:0] last_row;

  // window size to cell counts
  always_comb begin
    w_eff  = (item_q.pixel_width != 12'd0) ? item_q.pixel_width : width_q;
    h_eff  = (item_q.pixel_height != 12'd0) ? item_q.pixel_height : height_q;
    w_diff = w_eff - PAD_PIX;
    h_diff = h_eff - PAD_PIX;
    n_cols = w_diff[11:3];
    n_rows = h_diff[11:4];
    if (w_eff < PAD_PIX || int'(n_cols) < COLS_FLOOR) begin
      cols_new = CW'(COLS_FLOOR);
    end else if (int'(n_cols) > MAX_COLUMNS) begin
      cols_new = CW'(MAX_COLUMNS);
    end else begin
      cols_new = CW'(n_cols);
    end
    if (h_eff < PAD_PIX || int'(n_rows) < ROWS_FLOOR) begin
      rows_new = RW'(ROWS_FLOOR);
    end else if (int'(n_rows) > MAX_LINES) begin
      rows_new = RW'(MAX_LINES);
    end else begin
      rows_new = RW'(n_rows);
    end
  end

  // per-mode cursor update
  always_comb begin
    ex_col    = col_q;
    ex_line   = line_q;
    wa_col    = col_q;
    wa_line   = line_q;
    ex_wr     = 1'b0;
    ex_rd     = 1'b0;
    ex_scroll = 1'b0;
    ex_data   = CODE_SPACE;
    unique case (item_q.mode)
      MODE_PUT: begin
        if (item_q.char_code == CODE_NL) begin
          ex_col  = '0;
          ex_line = line_q + 1'b1;
        end else if (item_q.char_code == CODE_CR) begin
          ex_col = '0;
        end else if (line_q < RW'(MAX_LINES) && col_q < CW'(MAX_COLUMNS)) begin
          ex_wr   = 1'b1;
          ex_data = item_q.char_code;
          ex_col  = col_q + 1'b1;
        end
        if (ex_col >= cols_q) begin
          ex_col  = '0;
          ex_line = ex_line + 1'b1;
        end
        ex_scroll = (ex_line >= rows_q);
      end
      MODE_ERASE: begin
        if (col_q != '0) begin
          ex_col = col_q - 1'b1;
          ex_wr  = 1'b1;
        end else if (line_q != '0) begin
          ex_line = line_q - 1'b1;
          ex_col  = cols_q - 1'b1;
          ex_wr   = 1'b1;
        end
        ex_wr   = ex_wr && (ex_line < RW'(MAX_LINES)) && (ex_col < CW'(MAX_COLUMNS));
        wa_col  = ex_col;
        wa_line = ex_line;
      end
      MODE_RESIZE: begin
        ex_col    = (col_q >= cols_new) ? cols_new - 1'b1 : col_q;
        ex_scroll = (line_q >= rows_new);
      end
      MODE_READ: begin
        ex_rd = (int'(item_q.read_row) < MAX_LINES) && (int'(item_q.read_col) < MAX_COLUMNS);
      end
      default: begin
        ex_wr = 1'b0;
      end
    endcase
  end

  assign rows_lim = (rows_q > RW'(MAX_LINES)) ? RW'(MAX_LINES) : rows_q;
  assign last_row = rows_lim - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      item_q      <= '0;
      col_q       <= '0;
      line_q      <= '0;
      cols_q      <= CW'(RST_COLS);
      rows_q      <= RW'(RST_ROWS);
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      scrolled_q  <= 1'b0;
      pend_q      <= 1'b0;
      cell_q      <= '0;
      cmd_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cmd_q.op    <= OP_NONE;
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          if (store_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_q     <= item_i;
            scrolled_q <= 1'b0;
            cell_q     <= '0;
            state_q    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          col_q  <= ex_col;
          line_q <= ex_line;
          pend_q <= ex_scroll;
          if (item_q.mode == MODE_RESIZE) begin
            width_q  <= w_eff;
            height_q <= h_eff;
            cols_q   <= cols_new;
            rows_q   <= rows_new;
          end
          cmd_q.data     <= ex_data;
          cmd_q.blank_en <= 1'b0;
          if (ex_wr) begin
            cmd_q.op  <= OP_WRITE;
            cmd_q.row <= ROW_FW'(wa_line);
            cmd_q.col <= COL_FW'(wa_col);
            state_q   <= ST_CELL;
          end else if (ex_rd) begin
            cmd_q.op  <= OP_READ;
            cmd_q.row <= ROW_FW'(item_q.read_row);
            cmd_q.col <= COL_FW'(item_q.read_col);
            state_q   <= ST_CELL;
          end else if (ex_scroll) begin
            state_q <= ST_SCROLL;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_CELL: begin
          if (store_done) begin
            if (item_q.mode == MODE_READ) begin
              cell_q <= store_rdata;
            end
            state_q <= pend_q ? ST_SCROLL : ST_RESP;
          end
        end
        ST_SCROLL: begin
          cmd_q.op       <= OP_SCROLL;
          cmd_q.row      <= ROW_FW'(last_row);
          cmd_q.blank_en <= (rows_q <= RW'(MAX_LINES));
          line_q         <= rows_q - 1'b1;
          scrolled_q     <= 1'b1;
          state_q        <= ST_SWAIT;
        end
        ST_SWAIT: begin
          if (store_done) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          res_q.cursor_col   <= 7'(col_q);
          res_q.cursor_row   <= 6'(line_q);
          res_q.column_count <= 7'(cols_q);
          res_q.row_count    <= 7'(rows_q);
          res_q.cell_char    <= cell_q;
          res_q.scrolled     <= scrolled_q;
          res_valid_q        <= 1'b1;
          state_q            <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  ttce_cell_store #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_LINES  (MAX_LINES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .done_o (store_done),
    .rdata_o(store_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== design/ttce_checker.sv =====
// port-level checks for the terminal cursor engine and their bind
`timescale 1ns / 1ps
module ttce_checker import ttce_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start,
  input logic         busy,
  input logic         result_valid_o,
  input ttce_result_t result_o
);

  // one word out per strobe
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_result_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside end of busy period");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobe right after accept");

  a_scroll_flag_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(result_o.scrolled))
    else $error("scroll flag unknown on result");

endmodule

bind text_terminal_cursor_engine_core ttce_checker u_ttce_checker (.*);

// ===== tb/ttce_screen_checker.sv =====
// screen predictor and result checker for the terminal cursor engine testbench
`timescale 1ns / 1ps
module ttce_screen_checker import ttce_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  ttce_item_t   item_i,
  input  logic         result_valid_i,
  input  ttce_result_t result_i,
  output int           errors_o,
  output int           pending_o
);

  localparam int TERM_COLS = 120;
  localparam int TERM_ROWS = 64;
  localparam int GLYPH_W   = 8;
  localparam int GLYPH_H   = 16;

  logic [7:0]   screen [TERM_ROWS][TERM_COLS];
  int           cur_col;
  int           cur_row;
  int           cols_used;
  int           rows_used;
  int           win_w;
  int           win_h;
  bit           rolled;
  ttce_result_t screen_q [$];
  ttce_result_t want;

  function automatic void blank_screen();
    for (int r = 0; r < TERM_ROWS; r++) begin
      for (int c = 0; c < TERM_COLS; c++) begin
        screen[r][c] = CODE_SPACE;
      end
    end
    cur_col   = 0;
    cur_row   = 0;
    cols_used = RST_COLS;
    rows_used = RST_ROWS;
    win_w     = int'(RST_WIDTH);
    win_h     = int'(RST_HEIGHT);
  endfunction

  function automatic void roll_screen();
    for (int r = 0; r + 1 < rows_used && r + 1 < TERM_ROWS; r++) begin
      for (int c = 0; c < TERM_COLS; c++) begin
        screen[r][c] = screen[r + 1][c];
      end
    end
    if (rows_used - 1 < TERM_ROWS) begin
      for (int c = 0; c < TERM_COLS; c++) begin
        screen[rows_used - 1][c] = CODE_SPACE;
      end
    end
    cur_row = rows_used - 1;
    rolled  = 1'b1;
  endfunction

  function automatic void wrap_cursor();
    if (cur_col >= cols_used) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= rows_used) roll_screen();
  endfunction

  function automatic int fit_count(int size, int glyph, int lo, int hi);
    int n;
    if (size < int'(PAD_PIX)) return lo;
    n = (size - int'(PAD_PIX)) / glyph;
    if (n < lo) return lo;
    if (n > hi) return hi;
    return n;
  endfunction

  function automatic ttce_result_t apply_word(ttce_item_t w);
    ttce_result_t res;
    logic [7:0]   got;
    got    = '0;
    rolled = 1'b0;
    case (w.mode)
      MODE_PUT: begin
        if (w.char_code == CODE_NL) begin
          cur_col = 0;
          cur_row++;
        end else if (w.char_code == CODE_CR) begin
          cur_col = 0;
        end else begin
          wrap_cursor();
          if (cur_row < rows_used && cur_col < cols_used &&
              cur_row < TERM_ROWS && cur_col < TERM_COLS) begin
            screen[cur_row][cur_col] = w.char_code;
            cur_col++;
          end
        end
        wrap_cursor();
      end
      MODE_ERASE: begin
        if (cur_col > 0) begin
          cur_col--;
          screen[cur_row][cur_col] = CODE_SPACE;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = cols_used - 1;
          screen[cur_row][cur_col] = CODE_SPACE;
        end
      end
      MODE_RESIZE: begin
        if (w.pixel_width != 0) win_w = int'(w.pixel_width);
        if (w.pixel_height != 0) win_h = int'(w.pixel_height);
        cols_used = fit_count(win_w, GLYPH_W, COLS_FLOOR, TERM_COLS);
        rows_used = fit_count(win_h, GLYPH_H, ROWS_FLOOR, TERM_ROWS);
        if (cur_col >= cols_used) cur_col = cols_used - 1;
        if (cur_row >= rows_used) roll_screen();
      end
      MODE_READ: begin
        if (int'(w.read_col) < TERM_COLS) got = screen[w.read_row][w.read_col];
      end
    endcase
    res.cursor_col   = 7'(cur_col);
    res.cursor_row   = 6'(cur_row);
    res.column_count = 7'(cols_used);
    res.row_count    = 7'(rows_used);
    res.cell_char    = got;
    res.scrolled     = rolled;
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns mismatch in %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_screen();
      screen_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        if (screen_q.size() == 0) begin
          $display("%0t ns result word with none expected: %h", $time, result_i);
          errors_o++;
        end else begin
          want = screen_q.pop_front();
          check_field("cursor_col", want.cursor_col, result_i.cursor_col);
          check_field("cursor_row", want.cursor_row, result_i.cursor_row);
          check_field("column_count", want.column_count, result_i.column_count);
          check_field("row_count", want.row_count, result_i.row_count);
          check_field("cell_char", want.cell_char, result_i.cell_char);
          check_field("scrolled", want.scrolled, result_i.scrolled);
        end
      end
      if (start_i && !busy_i) screen_q.push_back(apply_word(item_i));
      pending_o = screen_q.size();
    end
  end

endmodule

// ===== tb/tb_text_terminal_cursor_engine_core.sv =====
// stimulus, watchdog and verdict for the terminal cursor engine
`timescale 1ns / 1ps
module tb_text_terminal_cursor_engine_core;
  import ttce_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASE_WORDS    = 450;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         start;
  logic         busy;
  ttce_item_t   item_i;
  logic         result_valid_o;
  ttce_result_t result_o;
  int           error_count;
  int           pending_count;
  int           idle_pct;
  int           stall_cycles = 0;

  always #6 clk_i = ~clk_i;

  text_terminal_cursor_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  ttce_screen_checker u_screen_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .errors_o       (error_count),
    .pending_o      (pending_count)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic ttce_item_t make_word(ttce_mode_e mode, logic [7:0] ch,
                                           logic [11:0] pw, logic [11:0] ph,
                                           logic [5:0] rr, logic [6:0] rc);
    ttce_item_t w;
    w.mode         = mode;
    w.char_code    = ch;
    w.pixel_width  = pw;
    w.pixel_height = ph;
    w.read_row     = rr;
    w.read_col     = rc;
    return w;
  endfunction

  function automatic ttce_item_t random_word();
    ttce_item_t w;
    int         pick;
    w.char_code    = 8'($urandom);
    w.pixel_width  = 12'($urandom);
    w.pixel_height = 12'($urandom);
    w.read_row     = 6'($urandom);
    w.read_col     = 7'($urandom);
    pick = $urandom_range(99);
    if (pick < 68) begin
      w.mode = MODE_PUT;
      pick = $urandom_range(99);
      if (pick < 9) w.char_code = CODE_NL;
      else if (pick < 14) w.char_code = CODE_CR;
      else if (pick < 80) w.char_code = 8'($urandom_range(8'h21, 8'h7e));
    end else if (pick < 78) begin
      w.mode = MODE_ERASE;
    end else if (pick < 83) begin
      w.mode = MODE_RESIZE;
      pick = $urandom_range(99);
      if (pick < 10) w.pixel_width = '0;
      else if (pick < 50) w.pixel_width = 12'($urandom_range(0, 500));
      pick = $urandom_range(99);
      if (pick < 80) w.pixel_height = 12'($urandom_range(0, 300));
      else if (pick < 95) w.pixel_height = 12'($urandom_range(0, 1100));
    end else begin
      w.mode = MODE_READ;
      if ($urandom_range(99) < 70) w.read_row = 6'($urandom_range(0, 15));
    end
    return w;
  endfunction

  task automatic send_word(input ttce_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(make_word(MODE_READ, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_READ, 8'hff, 12'hfff, 12'hfff, 6'd63, 7'd119));
    send_word(make_word(MODE_READ, 8'h00, 12'd0, 12'd0, 6'd10, 7'd127));
    send_word(make_word(MODE_ERASE, 8'h41, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, 8'hff, 12'hfff, 12'hfff, 6'd63, 7'd127));
    send_word(make_word(MODE_ERASE, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, CODE_CR, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, CODE_NL, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_ERASE, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_RESIZE, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_RESIZE, 8'h00, 12'hfff, 12'hfff, 6'd0, 7'd0));
    send_word(make_word(MODE_RESIZE, 8'h00, 12'd1, 12'd1, 6'd0, 7'd0));
    repeat (6) send_word(make_word(MODE_PUT, CODE_NL, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_ERASE, 8'h00, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, 8'h41, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_RESIZE, 8'h00, 12'd0, 12'd148, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, CODE_NL, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_PUT, CODE_NL, 12'd0, 12'd0, 6'd0, 7'd0));
    send_word(make_word(MODE_RESIZE, 8'h00, 12'hfff, 12'd1, 6'd0, 7'd0));
    send_word(make_word(MODE_READ, 8'h00, 12'd0, 12'd0, 6'd3, 7'd19));
    send_word(make_word(MODE_RESIZE, 8'h00, RST_WIDTH, RST_HEIGHT, 6'd0, 7'd0));

    idle_pct = 25;
    repeat (PHASE_WORDS) send_word(random_word());
    idle_pct = 72;
    repeat (PHASE_WORDS) send_word(random_word());
    idle_pct = 0;
    repeat (PHASE_WORDS) send_word(random_word());
    start <= 1'b0;

    do @(negedge clk_i); while (pending_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
